>>> rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared constants, codes and controller/datapath types of the min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned TAG_BITS = 16;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_LD,
    S_DN_RD,
    S_DN_CMP,
    S_FIN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load_in;
    logic    set_status;
    status_e status;
    logic    rd_root;
    logic    load_root;
    logic    rd_parent;
    logic    swap_up;
    logic    rd_kids;
    logic    swap_down;
    logic    place;
    logic    count_inc;
    logic    out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
    logic at_root;
    logic up_swap;
    logic has_child;
    logic dn_swap;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/bmhq_in_if.sv
// ----------------------------------------------------------------------------
// bmhq_in_if
// Request channel: operation code plus the entry to push.
// ----------------------------------------------------------------------------
interface bmhq_in_if #(
  parameter int unsigned KEY_BITS = bmhq_pkg::KEY_BITS,
  parameter int unsigned TAG_BITS = bmhq_pkg::TAG_BITS
);
  logic                valid;
  logic                ready;
  logic                func;
  logic [KEY_BITS-1:0] key_in;
  logic [TAG_BITS-1:0] tag_in;

  modport source (output valid, output func, output key_in, output tag_in, input ready);
  modport sink   (input valid, input func, input key_in, input tag_in, output ready);
endinterface

>>> rtl/bmhq_out_if.sv
// ----------------------------------------------------------------------------
// bmhq_out_if
// Response channel: status, popped entry and occupancy after the operation.
// ----------------------------------------------------------------------------
interface bmhq_out_if #(
  parameter int unsigned KEY_BITS = bmhq_pkg::KEY_BITS,
  parameter int unsigned TAG_BITS = bmhq_pkg::TAG_BITS,
  parameter int unsigned CNT_BITS = $clog2(bmhq_pkg::CAPACITY + 1)
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [KEY_BITS-1:0] key_out;
  logic [TAG_BITS-1:0] tag_out;
  logic [CNT_BITS-1:0] occupancy;

  modport source (output valid, output status, output key_out, output tag_out,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input key_out, input tag_out,
                  input occupancy, output ready);
endinterface

>>> rtl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue: push an entry, or pop the lowest key.
// ----------------------------------------------------------------------------
//  channel | dir | handshake      | payload
//  --------+-----+----------------+---------------------------------------
//  in_i    | in  | valid / ready  | func, key_in, tag_in
//  out_o   | out | valid / ready  | status, key_out, tag_out, occupancy
//
//  One transaction at a time. A push climbs from the new leaf until it
//  reaches the root or a compare stops it; a pop reads the root, moves the
//  last entry to the top and descends until it ends on a node with no child
//  or a compare stops it. Each sift level is one registered RAM read and one
//  compare/write step. Refused ops skip the sift and go straight to the output stage.
//  Reset clears the entry count; heap RAM contents are not cleared.
//  The output register holds a result while out_o is stalled; the next request
//  is still taken and only waits at its end for the register to free up.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
  parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY,
  parameter int unsigned KEY_BITS = bmhq_pkg::KEY_BITS,
  parameter int unsigned TAG_BITS = bmhq_pkg::TAG_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bmhq_in_if.sink           in_i,
  bmhq_out_if.source        out_o
);

  bmhq_pkg::cmd_t  cmd;
  bmhq_pkg::stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  bmhq_dp #(
    .CAPACITY(CAPACITY),
    .KEY_BITS(KEY_BITS),
    .TAG_BITS(TAG_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .func_i      (in_i.func),
    .key_i       (in_i.key_in),
    .tag_i       (in_i.tag_in),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_status_o(out_o.status),
    .out_key_o   (out_o.key_out),
    .out_tag_o   (out_o.tag_out),
    .out_occ_o   (out_o.occupancy)
  );

endmodule

>>> rtl/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

>>> rtl/bmhq_dp.sv
// ----------------------------------------------------------------------------
// bmhq_dp
// Datapath: heap RAM, entry count, sift position, moving entry, result and
// output registers, key comparators.
// ----------------------------------------------------------------------------
module bmhq_dp #(
  parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY,
  parameter int unsigned KEY_BITS = bmhq_pkg::KEY_BITS,
  parameter int unsigned TAG_BITS = bmhq_pkg::TAG_BITS,
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmhq_pkg::cmd_t      cmd_i,
  output bmhq_pkg::stat_t     stat_o,
  input  logic                func_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [TAG_BITS-1:0] tag_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          out_status_o,
  output logic [KEY_BITS-1:0] out_key_o,
  output logic [TAG_BITS-1:0] out_tag_o,
  output logic [CW-1:0]       out_occ_o
);

  localparam int unsigned IDX = $clog2(CAPACITY);
  localparam int unsigned EW  = KEY_BITS + TAG_BITS;

  logic [CW-1:0]       count_q;
  logic [IDX-1:0]      pos_q;
  logic [EW-1:0]       cur_q;
  logic                is_pop_q;
  bmhq_pkg::status_e   res_status_q;
  logic [KEY_BITS-1:0] res_key_q;
  logic [TAG_BITS-1:0] res_tag_q;
  logic                out_valid_q;
  logic [1:0]          out_status_q;
  logic [KEY_BITS-1:0] out_key_q;
  logic [TAG_BITS-1:0] out_tag_q;
  logic [CW-1:0]       out_occ_q;

  logic [IDX-1:0]      parent;
  logic [IDX+1:0]      lc_w, rc_w, cnt_w;
  logic [CW-1:0]       last_w;
  logic                rc_ok, pick_rc;
  logic [EW-1:0]       rdata0, rdata1, child, wdata;
  logic [KEY_BITS-1:0] k0, k1, cur_key, child_key;
  logic [IDX-1:0]      child_idx, raddr0, raddr1;
  logic                we, re;

  assign parent  = (pos_q - 1'b1) >> 1;
  assign lc_w    = {1'b0, pos_q, 1'b1};
  assign rc_w    = lc_w + 1'b1;
  assign cnt_w   = (IDX+2)'(count_q);
  assign last_w  = count_q - 1'b1;
  assign rc_ok   = rc_w < cnt_w;

  assign k0      = rdata0[EW-1 -: KEY_BITS];
  assign k1      = rdata1[EW-1 -: KEY_BITS];
  assign cur_key = cur_q[EW-1 -: KEY_BITS];

  // equal children: right one wins
  assign pick_rc   = rc_ok && !(k0 < k1);
  assign child     = pick_rc ? rdata1 : rdata0;
  assign child_idx = pick_rc ? rc_w[IDX-1:0] : lc_w[IDX-1:0];
  assign child_key = child[EW-1 -: KEY_BITS];

  always_comb begin
    raddr0 = '0;
    raddr1 = last_w[IDX-1:0];
    if (cmd_i.rd_parent) begin
      raddr0 = parent;
    end else if (cmd_i.rd_kids) begin
      raddr0 = lc_w[IDX-1:0];
      raddr1 = rc_w[IDX-1:0];
    end
  end

  assign re = cmd_i.rd_root | cmd_i.rd_parent | cmd_i.rd_kids;
  assign we = cmd_i.place | cmd_i.swap_up | cmd_i.swap_down;

  always_comb begin
    if (cmd_i.swap_up) begin
      wdata = rdata0;
    end else if (cmd_i.swap_down) begin
      wdata = child;
    end else begin
      wdata = cur_q;
    end
  end

  bmhq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(rdata0),
    .rdata1_o(rdata1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_root) begin
        count_q <= count_q - 1'b1;
      end else if (cmd_i.count_inc) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      is_pop_q     <= (func_i == bmhq_pkg::FUNC_POP);
      cur_q        <= {key_i, tag_i};
      pos_q        <= count_q[IDX-1:0];
      res_status_q <= bmhq_pkg::ST_OK;
      res_key_q    <= '0;
      res_tag_q    <= '0;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.status;
    end
    if (cmd_i.load_root) begin
      res_key_q <= k0;
      res_tag_q <= rdata0[TAG_BITS-1:0];
      cur_q     <= rdata1;
      pos_q     <= '0;
    end
    if (cmd_i.swap_up) begin
      pos_q <= parent;
    end
    if (cmd_i.swap_down) begin
      pos_q <= child_idx;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_tag_q    <= res_tag_q;
      out_occ_q    <= count_q;
    end
  end

  assign stat_o.is_pop    = is_pop_q;
  assign stat_o.full      = (count_q == CW'(CAPACITY));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.at_root   = (pos_q == '0);
  assign stat_o.up_swap   = (k0 > cur_key);
  assign stat_o.has_child = (lc_w < cnt_w);
  assign stat_o.dn_swap   = (cur_key > child_key);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_key_o    = out_key_q;
  assign out_tag_o    = out_tag_q;
  assign out_occ_o    = out_occ_q;

endmodule

>>> rtl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer: accepts a request, walks the sift loop one level per read/compare
// pair, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bmhq_pkg::stat_t stat_i,
  output bmhq_pkg::cmd_t  cmd_o
);

  bmhq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bmhq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = bmhq_pkg::S_DECIDE;
        end
      end
      bmhq_pkg::S_DECIDE: begin
        if (!stat_i.is_pop) begin
          if (stat_i.full) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = bmhq_pkg::ST_FULL;
            state_d          = bmhq_pkg::S_FIN;
          end else begin
            state_d = bmhq_pkg::S_UP_RD;
          end
        end else if (stat_i.empty) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = bmhq_pkg::ST_EMPTY;
          state_d          = bmhq_pkg::S_FIN;
        end else begin
          cmd_o.rd_root = 1'b1;
          state_d       = bmhq_pkg::S_POP_LD;
        end
      end
      bmhq_pkg::S_UP_RD: begin
        if (stat_i.at_root) begin
          cmd_o.place     = 1'b1;
          cmd_o.count_inc = 1'b1;
          state_d         = bmhq_pkg::S_FIN;
        end else begin
          cmd_o.rd_parent = 1'b1;
          state_d         = bmhq_pkg::S_UP_CMP;
        end
      end
      bmhq_pkg::S_UP_CMP: begin
        if (stat_i.up_swap) begin
          cmd_o.swap_up = 1'b1;
          state_d       = bmhq_pkg::S_UP_RD;
        end else begin
          cmd_o.place     = 1'b1;
          cmd_o.count_inc = 1'b1;
          state_d         = bmhq_pkg::S_FIN;
        end
      end
      bmhq_pkg::S_POP_LD: begin
        cmd_o.load_root = 1'b1;
        state_d         = bmhq_pkg::S_DN_RD;
      end
      bmhq_pkg::S_DN_RD: begin
        if (stat_i.has_child) begin
          cmd_o.rd_kids = 1'b1;
          state_d       = bmhq_pkg::S_DN_CMP;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = bmhq_pkg::S_FIN;
        end
      end
      bmhq_pkg::S_DN_CMP: begin
        if (stat_i.dn_swap) begin
          cmd_o.swap_down = 1'b1;
          state_d         = bmhq_pkg::S_DN_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = bmhq_pkg::S_FIN;
        end
      end
      bmhq_pkg::S_FIN: begin
        // wait for the output register to free up
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = bmhq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bmhq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/bmhq_checker.sv
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks of the min-heap queue response channel.
// ----------------------------------------------------------------------------
module bmhq_checker #(
  parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY,
  parameter int unsigned KEY_BITS = bmhq_pkg::KEY_BITS,
  parameter int unsigned TAG_BITS = bmhq_pkg::TAG_BITS,
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [1:0]          out_status_i,
  input logic [KEY_BITS-1:0] out_key_i,
  input logic [TAG_BITS-1:0] out_tag_i,
  input logic [CW-1:0]       out_occ_i
);

  // stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i)
      && $stable(out_key_i) && $stable(out_tag_i) && $stable(out_occ_i))
    else $error("response changed while stalled");

  // refused op carries no entry
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != bmhq_pkg::ST_OK |-> out_key_i == '0 && out_tag_i == '0)
    else $error("refused op returned an entry");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == bmhq_pkg::ST_FULL |-> out_occ_i == CW'(CAPACITY))
    else $error("full refusal with heap not full");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == bmhq_pkg::ST_EMPTY |-> out_occ_i == '0)
    else $error("empty refusal with heap not empty");

endmodule

bind binary_min_heap_queue bmhq_checker #(
  .CAPACITY(CAPACITY),
  .KEY_BITS(KEY_BITS),
  .TAG_BITS(TAG_BITS)
) u_bmhq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_status_i(out_o.status),
  .out_key_i   (out_o.key_out),
  .out_tag_i   (out_o.tag_out),
  .out_occ_i   (out_o.occupancy)
);

>>> bench/bmhq_heap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmhq_heap_checker
// Watches both channels of the min-heap queue. It keeps a mirror heap that is
// updated for every accepted request. Each response is then compared field by
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bmhq_heap_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  bmhq_in_if    in_mon,
  bmhq_out_if   out_mon,
  output int    err_cnt_o,
  output int    pending_o,
  output int    pop_cnt_o,
  output int    full_cnt_o,
  output int    empty_cnt_o
);
  import bmhq_pkg::*;

  localparam int unsigned OCC_BITS = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    status_e             status;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
    logic [OCC_BITS-1:0] occ;
  } resp_t;

  entry_t      mirror_heap [CAPACITY];
  int unsigned mirror_cnt;
  resp_t       expected_resp [$];
  int          errs, pops, fulls, empties;

  assign err_cnt_o   = errs;
  assign pop_cnt_o   = pops;
  assign full_cnt_o  = fulls;
  assign empty_cnt_o = empties;

  // Applies one request to the mirror heap and returns the response it implies.
  function automatic resp_t heap_apply(input logic f, input logic [KEY_BITS-1:0] k,
                                       input logic [TAG_BITS-1:0] t);
    resp_t       r;
    entry_t      tmp;
    int unsigned pos, up, lc, rc, c;
    bit          done;
    r        = '0;
    r.status = ST_OK;
    done     = 1'b0;
    pos      = 0;
    if (f == FUNC_PUSH) begin
      if (mirror_cnt >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pos = mirror_cnt;
        mirror_heap[pos] = '{key: k, tag: t};
        // climb only while the parent is strictly larger
        while (pos != 0 && !done) begin
          up = (pos - 1) / 2;
          if (mirror_heap[up].key > mirror_heap[pos].key) begin
            tmp = mirror_heap[up];
            mirror_heap[up] = mirror_heap[pos];
            mirror_heap[pos] = tmp;
            pos = up;
          end else begin
            done = 1'b1;
          end
        end
        mirror_cnt++;
      end
    end else begin
      if (mirror_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key = mirror_heap[0].key;
        r.tag = mirror_heap[0].tag;
        mirror_heap[0] = mirror_heap[mirror_cnt-1];
        mirror_cnt--;
        while (2*pos + 1 < mirror_cnt && !done) begin
          lc = 2*pos + 1;
          rc = 2*pos + 2;
          // equal children: right one wins
          if (rc >= mirror_cnt || mirror_heap[lc].key < mirror_heap[rc].key) c = lc;
          else c = rc;
          if (mirror_heap[pos].key > mirror_heap[c].key) begin
            tmp = mirror_heap[pos];
            mirror_heap[pos] = mirror_heap[c];
            mirror_heap[c] = tmp;
            pos = c;
          end else begin
            done = 1'b1;
          end
        end
      end
    end
    r.occ = mirror_cnt[OCC_BITS-1:0];
    return r;
  endfunction

  task automatic flag_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    resp_t e;
    if (!rst_ni) begin
      mirror_cnt = 0;
      foreach (mirror_heap[i]) mirror_heap[i] = '0;
      expected_resp.delete();
      errs      = 0;
      pops      = 0;
      fulls     = 0;
      empties   = 0;
      pending_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_resp.size() == 0) begin
          $display("%0t: response with nothing outstanding, expected none, actual status %0d key %0h tag %0h occ %0d",
                   $time, out_mon.status, out_mon.key_out, out_mon.tag_out,
                   out_mon.occupancy);
          errs++;
        end else begin
          e = expected_resp.pop_front();
          flag_field("status", 64'(e.status), 64'(out_mon.status));
          flag_field("key_out", 64'(e.key), 64'(out_mon.key_out));
          flag_field("tag_out", 64'(e.tag), 64'(out_mon.tag_out));
          flag_field("occupancy", 64'(e.occ), 64'(out_mon.occupancy));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        e = heap_apply(in_mon.func, in_mon.key_in, in_mon.tag_in);
        if (e.status == ST_FULL) fulls++;
        else if (e.status == ST_EMPTY) empties++;
        else if (in_mon.func == FUNC_POP) pops++;
        expected_resp.push_back(e);
      end
      pending_o = expected_resp.size();
    end
  end

endmodule

>>> bench/binary_min_heap_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_tb
// Drives push/pop requests into the min-heap queue: a directed opening, then
// fill-to-full and drain-to-empty runs and random mixes. Key ranges are narrow
// for ties and wide for spread. Three idle phases shift the stall pressure
// between the two sides. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_tb;
  import bmhq_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 533;
  localparam int DRAIN_CYCLES = 40;

  logic clk_i;
  logic rst_ni;
  int   send_idle, recv_idle;
  int   items_sent, phase_sent, cycles;
  int   err_cnt, pending, pop_cnt, full_cnt, empty_cnt;

  bmhq_in_if  in_if ();
  bmhq_out_if out_if ();

  binary_min_heap_queue u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bmhq_heap_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .pop_cnt_o   (pop_cnt),
    .full_cnt_o  (full_cnt),
    .empty_cnt_o (empty_cnt)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    out_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready = ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
      $display("FAIL");
      $finish;
    end
  end

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_op(input logic f, input logic [KEY_BITS-1:0] k,
                         input logic [TAG_BITS-1:0] t);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid  = 1'b1;
    in_if.func   = f;
    in_if.key_in = k;
    in_if.tag_in = t;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    items_sent++;
    phase_sent++;
  endtask

  // narrow keys force ties, the rest spread over the whole range
  function automatic logic [KEY_BITS-1:0] pick_key(input bit narrow);
    int sel;
    sel = $urandom_range(9);
    if (narrow || sel < 3) return KEY_BITS'($urandom_range(7));
    if (sel == 3) return '0;
    if (sel == 4) return '1;
    if (sel == 5) return '1 - KEY_BITS'($urandom_range(3));
    return KEY_BITS'($urandom);
  endfunction

  task automatic push_rand(input bit narrow);
    send_op(FUNC_PUSH, pick_key(narrow), TAG_BITS'($urandom));
  endtask

  task automatic pop_one();
    send_op(FUNC_POP, KEY_BITS'($urandom), TAG_BITS'($urandom));
  endtask

  initial begin
    bit narrow;
    int push_pct, seg_len;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.func   = FUNC_PUSH;
    in_if.key_in = '0;
    in_if.tag_in = '0;
    send_idle    = 36;
    recv_idle    = 66;
    items_sent   = 0;
    cycles       = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle  = (phase == 0) ? 36 : (phase == 1) ? 66 : 0;
      recv_idle  = (phase == 0) ? 66 : (phase == 1) ? 36 : 0;
      phase_sent = 0;

      if (phase == 0) begin
        pop_one();                              // pop from an empty heap
        send_op(FUNC_PUSH, '0, '1);
        send_op(FUNC_PUSH, '1, '0);
        send_op(FUNC_PUSH, '1, '1);
        for (int i = 1; i <= 4; i++) send_op(FUNC_PUSH, KEY_BITS'(5), TAG_BITS'(i));
        send_op(FUNC_PUSH, KEY_BITS'(3), TAG_BITS'(16'h5a5a));
        send_op(FUNC_PUSH, KEY_BITS'(5), TAG_BITS'(16'ha5a5));
        repeat (11) pop_one();                  // last two hit an empty heap
      end

      // fill past capacity, then drain past empty
      narrow = $urandom_range(1);
      repeat (CAPACITY + 2) push_rand(narrow);
      repeat (CAPACITY + 2) pop_one();

      while (phase_sent < PHASE_ITEMS) begin
        case ($urandom_range(2))
          0:       push_pct = 20;
          1:       push_pct = 50;
          default: push_pct = 80;
        endcase
        narrow  = ($urandom_range(2) == 0);
        seg_len = $urandom_range(20, 120);
        repeat (seg_len) begin
          if ($urandom_range(99) < push_pct) push_rand(narrow);
          else pop_one();
        end
      end
    end
    in_if.valid = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d requests over three stall phases; %0d pops returned entries,",
             items_sent, pop_cnt);
    $display("%0d pushes refused when full and %0d pops refused when empty.",
             full_cnt, empty_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
